/* hw/rtl/kmeans_centroid_update_macros.svh */
// Assertion macros for the centroid update block.
// Used by the port checker; no other dependencies.
`ifndef KMEANS_CENTROID_UPDATE_MACROS_SVH
`define KMEANS_CENTROID_UPDATE_MACROS_SVH
`define KCU_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define KCU_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

/* hw/rtl/kcu_pkg.sv */
// Shared types and constants for the centroid update block.
// No dependencies.
package kcu_pkg;
    localparam int MaxClusters = 16;
    localparam int IdxW = $clog2(MaxClusters);
    localparam int MemW = 4 * 64 + 32;
    localparam logic [63:0] EmptyMark = 64'h07FF_FFFF_FFFF_FFFF;
    localparam logic [4:0] ActiveReset = 5'd16;

    typedef struct packed {
        logic [3:0]  cluster;
        logic signed [63:0] part_sum_x;
        logic signed [63:0] part_sum_y;
        logic signed [63:0] part_sum_z;
        logic signed [63:0] part_sum_w;
        logic [31:0] part_count;
        logic        last_part;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  out_cluster;
        logic signed [63:0] centroid_x;
        logic signed [63:0] centroid_y;
        logic signed [63:0] centroid_z;
        logic signed [63:0] centroid_w;
        logic [31:0] total_points;
        logic        cluster_empty;
        logic        last_centroid;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [63:0] sx, sy, sz, sw;
        logic [31:0] cnt;
    } t_div_req;
endpackage

/* hw/rtl/kcu_divider.sv */
// Four-lane restoring divider: 64-bit signed sums over a 32-bit count.
// One quotient bit per lane per cycle. Depends on kcu_pkg.
module kcu_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kcu_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [63:0]       o_q [4]
);
    import kcu_pkg::*;
    logic [63:0] r_mag [4];
    logic [63:0] r_quo [4];
    logic [32:0] r_rem [4];
    logic [3:0]  r_neg;
    logic [31:0] r_div;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] w_s [4];

    assign w_s[0] = i_req.sx;
    assign w_s[1] = i_req.sy;
    assign w_s[2] = i_req.sz;
    assign w_s[3] = i_req.sw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic [32:0] t;
        if (i_req.start) begin
            r_div <= i_req.cnt;
            for (int l = 0; l < 4; l++) begin
                r_neg[l] <= w_s[l][63];
                r_mag[l] <= w_s[l][63] ? (64'd0 - w_s[l]) : w_s[l];
                r_rem[l] <= 33'd0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < 4; l++) begin
                t = {r_rem[l][31:0], r_mag[l][63]};
                r_mag[l] <= {r_mag[l][62:0], 1'b0};
                if (t >= {1'b0, r_div}) begin
                    r_rem[l] <= t - {1'b0, r_div};
                    r_quo[l] <= {r_quo[l][62:0], 1'b1};
                end else begin
                    r_rem[l] <= t;
                    r_quo[l] <= {r_quo[l][62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 7'd63);
        end
    end

    assign o_done = r_done;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            o_q[l] = r_neg[l] ? (64'd0 - r_quo[l]) : r_quo[l];
        end
    end
endmodule

/* hw/rtl/kmeans_centroid_update.sv */
// Top level of the centroid update block.
// Depends on kcu_pkg and kcu_divider.
//
// Input items carry one cluster's partial sums and point count. Each item
// for an active cluster is added into the cluster's accumulator entry by a
// read-modify-write of the accumulator memory: read at acceptance, add and
// write in the next cycle. An item for the entry still being written takes
// the forwarded sum. Accumulation sustains one item per cycle. An item with
// last_part set starts an emit pass: one result per active cluster in index
// order. Each entry is read, divided by a four-lane bit-serial divider,
// then presented; the entry is cleared as it is read. No input item is
// accepted during a pass. A stalled receiver holds the output register and
// the pass waits. Reset clears the memory by a clearing pass, in which no
// item is accepted; the configuration port is always ready and sets the
// active cluster count (0 acts as 1, above 16 as 16).
module kmeans_centroid_update (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kcu_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kcu_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [4:0]          i_cfg_data
);
    import kcu_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_ACC   = 6'b000010,
        S_RD    = 6'b000100,
        S_LOAD  = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [4:0] r_active;
    logic [IdxW-1:0] r_idx;
    logic [MemW-1:0] r_mem [MaxClusters];
    logic [MemW-1:0] r_rd;
    logic r_wb_v;
    logic [IdxW-1:0] r_wb_idx;
    logic [MemW-1:0] r_wb_data;
    t_in_item r_item;
    logic r_item_v, r_last_pend;
    t_out_item r_out;
    logic r_out_v;
    logic [4:0] w_k;
    logic [IdxW-1:0] w_kmax;
    logic w_acc_in, w_upd;
    logic [MemW-1:0] w_base, w_sum;
    logic [32:0] w_cnt;
    t_div_req w_req;
    logic w_done;
    logic [63:0] w_q [4];
    logic [MemW-1:0] r_ent;

    assign w_k = (r_active == 5'd0) ? 5'd1 :
        (r_active > 5'(MaxClusters)) ? 5'(MaxClusters) : r_active;
    assign w_kmax = IdxW'(w_k - 5'd1);
    assign o_cfg_ready = 1'b1;
    assign o_in_ready = (r_state == S_ACC) && !r_last_pend;
    assign w_acc_in = i_in_valid && o_in_ready;

    assign w_base = (r_wb_v && r_wb_idx == r_item.cluster[IdxW-1:0]) ? r_wb_data : r_rd;
    assign w_cnt = {1'b0, w_base[31:0]} + {1'b0, r_item.part_count};
    assign w_sum = {w_base[MemW-1 -: 64] + r_item.part_sum_x,
                    w_base[MemW-65 -: 64] + r_item.part_sum_y,
                    w_base[MemW-129 -: 64] + r_item.part_sum_z,
                    w_base[MemW-193 -: 64] + r_item.part_sum_w,
                    w_cnt[32] ? 32'hFFFF_FFFF : w_cnt[31:0]};
    assign w_upd = r_item_v && ({1'b0, r_item.cluster} < w_k);

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_mem[r_idx] <= '0;
        end else if (r_state == S_RD) begin
            r_mem[r_idx] <= '0;
        end else if (w_upd) begin
            r_mem[r_item.cluster[IdxW-1:0]] <= w_sum;
        end
        r_rd <= r_mem[(r_state == S_ACC) ? i_in_data.cluster[IdxW-1:0] : r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_v <= 1'b0;
            r_item_v <= 1'b0;
            r_last_pend <= 1'b0;
            r_active <= ActiveReset;
        end else begin
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
            r_wb_v <= w_upd;
            r_item_v <= w_acc_in;
            if (w_acc_in && i_in_data.last_part) begin
                r_last_pend <= 1'b1;
            end else if (r_state == S_RD) begin
                r_last_pend <= 1'b0;
            end
        end
        r_wb_idx <= r_item.cluster[IdxW-1:0];
        r_wb_data <= w_sum;
        if (w_acc_in) begin
            r_item <= i_in_data;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_idx == IdxW'(MaxClusters - 1)) n_state = S_ACC;
            S_ACC:   if (r_last_pend && !r_item_v && !r_wb_v) n_state = S_RD;
            S_RD:    n_state = S_LOAD;
            S_LOAD:  n_state = S_DIV;
            S_DIV:   if (w_done) n_state = S_OUT;
            S_OUT:   if (!r_out_v || i_out_ready) begin
                n_state = (r_idx == w_kmax) ? S_ACC : S_RD;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign w_req.start = (r_state == S_LOAD);
    assign w_req.sx = r_rd[MemW-1 -: 64];
    assign w_req.sy = r_rd[MemW-65 -: 64];
    assign w_req.sz = r_rd[MemW-129 -: 64];
    assign w_req.sw = r_rd[MemW-193 -: 64];
    assign w_req.cnt = (r_rd[31:0] == 32'd0) ? 32'd1 : r_rd[31:0];

    kcu_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_done (w_done),
        .o_q    (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_state == S_OUT && (!r_out_v || i_out_ready)) begin
                r_out_v <= 1'b1;
                r_idx <= (r_idx == w_kmax) ? '0 : r_idx + 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
        if (r_state == S_LOAD) begin
            r_ent <= r_rd;
        end
        if (r_state == S_OUT && (!r_out_v || i_out_ready)) begin
            r_out.out_cluster <= 4'(r_idx);
            r_out.total_points <= r_ent[31:0];
            r_out.cluster_empty <= (r_ent[31:0] == 32'd0);
            r_out.last_centroid <= (r_idx == w_kmax);
            r_out.centroid_x <= (r_ent[31:0] == 32'd0) ? EmptyMark : w_q[0];
            r_out.centroid_y <= (r_ent[31:0] == 32'd0) ? EmptyMark : w_q[1];
            r_out.centroid_z <= (r_ent[31:0] == 32'd0) ? EmptyMark : w_q[2];
            r_out.centroid_w <= (r_ent[31:0] == 32'd0) ? EmptyMark : w_q[3];
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data = r_out;
endmodule

/* hw/rtl/kcu_checker.sv */
// Port-level checker for the centroid update block, bound to the top level.
// Depends on kcu_pkg and the assertion macro header.
`include "kmeans_centroid_update_macros.svh"
module kcu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input kcu_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input kcu_pkg::t_out_item o_out_data
);
    import kcu_pkg::*;
    `KCU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "Stalled result changed.")
    `KCU_ASSERT_IMP(a_empty_mark, i_clk, i_rst_n, o_out_valid && o_out_data.cluster_empty, o_out_data.centroid_x == EmptyMark && o_out_data.total_points == 32'd0, "Empty cluster without sentinel.")
    `KCU_ASSERT_NXT(a_last_blocks, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_data.last_part, !o_in_ready, "Item accepted after last part.")
    `KCU_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_in_ready, !o_out_valid || o_out_data.last_centroid, "Input taken during emit pass.")
endmodule

bind kmeans_centroid_update kcu_checker u_kcu_checker (.*);

/* verif/kmeans_centroid_update_tb.sv */
// Self-checking testbench for the k-means centroid update block.
// Depends on kcu_pkg and the kmeans_centroid_update RTL; predicts each emit pass.
`timescale 1ns / 1ps

module kmeans_centroid_update_tb;
    import kcu_pkg::*;

    localparam int WatchLimit = 20000;
    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;

    kmeans_centroid_update i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_item   pending_items[$];
    t_out_item  expected_centroids[$];
    logic [63:0] acc_x[MaxClusters], acc_y[MaxClusters], acc_z[MaxClusters], acc_w[MaxClusters];
    logic [31:0] acc_cnt[MaxClusters];
    logic [4:0]  active_reg = ActiveReset;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          errors = 0;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;

    function automatic logic [63:0] trunc_mean(logic [63:0] s, logic [31:0] c);
        logic [63:0] mag;
        logic [63:0] q;
        mag = s[63] ? -s : s;
        q = mag / {32'd0, c};
        return s[63] ? -q : q;
    endfunction

    function automatic int active_count();
        if (active_reg == 0) return 1;
        if (active_reg > MaxClusters) return MaxClusters;
        return active_reg;
    endfunction

    task automatic predict_centroids(t_in_item it);
        int k;
        logic [32:0] total;
        t_out_item r;
        k = active_count();
        if (it.cluster < k) begin
            acc_x[it.cluster] += it.part_sum_x;
            acc_y[it.cluster] += it.part_sum_y;
            acc_z[it.cluster] += it.part_sum_z;
            acc_w[it.cluster] += it.part_sum_w;
            total = {1'b0, acc_cnt[it.cluster]} + {1'b0, it.part_count};
            acc_cnt[it.cluster] = total[32] ? CountMax : total[31:0];
        end
        if (it.last_part) begin
            for (int i = 0; i < k; i++) begin
                r.out_cluster = i[3:0];
                r.total_points = acc_cnt[i];
                r.cluster_empty = (acc_cnt[i] == 0);
                r.last_centroid = (i == k - 1);
                if (acc_cnt[i] == 0) begin
                    r.centroid_x = EmptyMark;
                    r.centroid_y = EmptyMark;
                    r.centroid_z = EmptyMark;
                    r.centroid_w = EmptyMark;
                end else begin
                    r.centroid_x = trunc_mean(acc_x[i], acc_cnt[i]);
                    r.centroid_y = trunc_mean(acc_y[i], acc_cnt[i]);
                    r.centroid_z = trunc_mean(acc_z[i], acc_cnt[i]);
                    r.centroid_w = trunc_mean(acc_w[i], acc_cnt[i]);
                end
                expected_centroids.push_back(r);
            end
            for (int i = 0; i < MaxClusters; i++) begin
                acc_x[i] = '0; acc_y[i] = '0; acc_z[i] = '0; acc_w[i] = '0; acc_cnt[i] = '0;
            end
        end
    endtask

    // Driver: presents queued items and holds each until accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_centroids(i_in_data);
                void'(pending_items.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_items[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compares each accepted centroid with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && i_out_ready) begin
                if (expected_centroids.size() == 0) begin
                    $display("%0t: unexpected centroid, expected none, actual %h",
                             $time, o_out_data);
                    errors++;
                end else begin
                    if (o_out_data !== expected_centroids[0]) begin
                        $display("%0t: centroid mismatch, expected %h, actual %h",
                                 $time, expected_centroids[0], o_out_data);
                        errors++;
                    end
                    void'(expected_centroids.pop_front());
                end
            end
        end
    end

    function automatic logic [63:0] rand_sum();
        case ($urandom_range(5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return {{32{1'b0}}, $urandom()} - 64'h8000_0000;
            3: return {$urandom(), $urandom()};
            default: return 64'($signed($urandom_range(2000))) - 64'sd1000;
        endcase
    endfunction

    function automatic t_in_item make_item(int k, bit last);
        t_in_item it;
        it.cluster = ($urandom_range(9) == 0) ? 4'($urandom()) : 4'($urandom_range(k - 1));
        it.part_sum_x = rand_sum();
        it.part_sum_y = rand_sum();
        it.part_sum_z = rand_sum();
        it.part_sum_w = rand_sum();
        case ($urandom_range(7))
            0: it.part_count = 0;
            1: it.part_count = $urandom();
            2: it.part_count = CountMax;
            default: it.part_count = $urandom_range(50);
        endcase
        it.last_part = last;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_in_valid || expected_centroids.size() > 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_active(logic [4:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        active_reg = v;
    endtask

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (idle_cycles >= WatchLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_in_item it;
        int k;
        logic [4:0] settings[6];
        settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17};
        for (int i = 0; i < MaxClusters; i++) begin
            acc_x[i] = '0; acc_y[i] = '0; acc_z[i] = '0; acc_w[i] = '0; acc_cnt[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: extremes, count overflow, empty clusters, inactive index.
        it = '0;
        it.cluster = 0; it.part_sum_x = 64'h8000_0000_0000_0000;
        it.part_sum_y = 64'h7FFF_FFFF_FFFF_FFFF; it.part_sum_z = -64'sd7;
        it.part_sum_w = 64'sd7; it.part_count = 3;
        pending_items.push_back(it);
        it.cluster = 15; it.part_count = CountMax; pending_items.push_back(it);
        it.part_count = 5; pending_items.push_back(it);
        it.cluster = 3; it.part_sum_x = -64'sd1; it.part_count = 2;
        it.last_part = 1'b1; pending_items.push_back(it);
        it = '0; it.last_part = 1'b1; pending_items.push_back(it);
        wait_drained();
        write_active(5'd2);
        it = '0; it.cluster = 9; it.part_count = 4; it.part_sum_x = 64'sd100;
        it.last_part = 1'b1; pending_items.push_back(it);
        it.cluster = 1; it.part_sum_x = -64'sd9; pending_items.push_back(it);
        wait_drained();
        for (int ph = 0; ph < 6; ph++) begin
            write_active(settings[ph]);
            k = active_count();
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 60; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 60; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (int n = 0; n < 55; n++)
                pending_items.push_back(make_item(k, ($urandom_range(7) == 0) || n == 54));
            wait_drained();
        end
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
